// File: rtl/core/lesf_pkg.sv
`default_nettype none
package lesf_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    localparam int CHAR_W = 8;
    localparam int SIZE_W = 11;
    localparam int COL_W  = 10;
    localparam int ROW_W  = 11;
    localparam int OUT_W  = 10;
    localparam int CFG_W  = 11;

    localparam logic [CHAR_W-1:0] FREE_CELL      = 8'd46;
    localparam logic [CFG_W-1:0]  MAP_COLS_RESET = 11'd16;

    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [OUT_W-1:0]  out_pos_t;

    // Position of one cell beat in the map
    typedef struct packed {
        col_t col;
        row_t row;
        logic ignore;
    } pos_t;

    function automatic size_t min3(input size_t a, input size_t b, input size_t c);
        size_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    // Saturate at MAX_ROWS
    function automatic row_t row_inc(input row_t r);
        return (r < ROW_W'(MAX_ROWS)) ? ROW_W'(r + 1'b1) : r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/lesf_if.sv
`default_nettype none
interface lesf_cell_if;
    logic                        valid;
    logic                        ready;
    logic [lesf_pkg::CHAR_W-1:0] cell_char;
    logic                        last_cell;

    modport source (output valid, output cell_char, output last_cell, input ready);
    modport sink   (input valid, input cell_char, input last_cell, output ready);
endinterface

interface lesf_result_if;
    logic                       valid;
    logic                       ready;
    logic [lesf_pkg::SIZE_W-1:0] best_size;
    logic [lesf_pkg::OUT_W-1:0]  best_row;
    logic [lesf_pkg::OUT_W-1:0]  best_col;
    logic                        row_overflow;

    modport source (output valid, output best_size, output best_row, output best_col,
                    output row_overflow, input ready);
    modport sink   (input valid, input best_size, input best_row, input best_col,
                    input row_overflow, output ready);
endinterface
`default_nettype wire

// File: rtl/core/largest_empty_square_finder_top.sv
// A result beat is offered once the last cell beat has left stage 1.
// Throughput: one cell beat per cycle while not stalled; the line buffer is read
// on acceptance and written as the beat leaves stage 1, with a one-entry bypass
// for a one-column map. The input stalls only while a finished result waits and
// stage 1 holds another last cell. Reset clears position, best-square state, result
// valid and sets map_cols to 16; the line buffer is not cleared (row 0 ignores it).
`default_nettype none
module largest_empty_square_finder_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    lesf_cell_if.sink                       cells,
    lesf_result_if.source                   result,
    input  wire logic                       cfg_wr_en,
    input  wire logic [lesf_pkg::CFG_W-1:0] cfg_wr_data
);

    logic [lesf_pkg::CFG_W-1:0] map_cols_reg;

    logic                          accept;
    logic                          s1_adv;
    lesf_pkg::pos_t                pos;

    logic                          s1_valid_reg;
    logic                          s1_free_reg;
    logic                          s1_last_reg;
    lesf_pkg::pos_t                s1_pos_reg;
    lesf_pkg::size_t               rd_data_reg;
    logic                          fwd_reg;
    lesf_pkg::size_t               fwd_val_reg;

    lesf_pkg::size_t               line_mem [lesf_pkg::MAX_COLS];

    lesf_pkg::size_t               left_reg, upleft_reg, max_reg;
    lesf_pkg::out_pos_t            top_row_reg, left_col_reg;
    logic                          ovf_reg;

    lesf_pkg::size_t               up, left, upleft, size_cur;
    logic                          wr_en, better;
    lesf_pkg::out_pos_t            top_row_cur, left_col_cur;

    logic                          out_valid_reg;
    lesf_pkg::size_t               out_size_reg;
    lesf_pkg::out_pos_t            out_row_reg, out_col_reg;
    logic                          out_ovf_reg;

    assign accept      = cells.valid && cells.ready;
    assign s1_adv      = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign cells.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_cols_reg <= lesf_pkg::MAP_COLS_RESET;
        end
        else if (cfg_wr_en)
        begin
            map_cols_reg <= cfg_wr_data;
        end
    end

    lesf_pos u_pos (
        .clk      (clk),
        .rst_n    (rst_n),
        .map_cols (map_cols_reg),
        .advance  (accept),
        .last     (cells.last_cell),
        .pos      (pos)
    );

    always_comb
    begin
        if (s1_pos_reg.row == '0)
        begin
            up = '0;
        end
        else
        begin
            up = fwd_reg ? fwd_val_reg : rd_data_reg;
        end
        left   = (s1_pos_reg.col == '0) ? '0 : left_reg;
        upleft = (s1_pos_reg.col == '0 || s1_pos_reg.row == '0) ? '0 : upleft_reg;

        size_cur = s1_free_reg
                 ? lesf_pkg::SIZE_W'(lesf_pkg::min3(up, left, upleft) + 1'b1) : '0;

        wr_en  = s1_adv && !s1_pos_reg.ignore;
        better = !s1_pos_reg.ignore && (size_cur > max_reg);

        // Top-left corner of the square ending here
        top_row_cur  = lesf_pkg::OUT_W'(s1_pos_reg.row[lesf_pkg::OUT_W-1:0] + 1'b1
                                        - size_cur[lesf_pkg::OUT_W-1:0]);
        left_col_cur = lesf_pkg::OUT_W'(s1_pos_reg.col + 1'b1
                                        - size_cur[lesf_pkg::OUT_W-1:0]);
    end

    // Line buffer and stage-1 payload
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[s1_pos_reg.col] <= size_cur;
        end
        if (accept)
        begin
            rd_data_reg <= line_mem[pos.col];
            s1_free_reg <= (cells.cell_char == lesf_pkg::FREE_CELL);
            s1_last_reg <= cells.last_cell;
            s1_pos_reg  <= pos;
            fwd_val_reg <= size_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                // Bypass a write landing on the address being read
                fwd_reg      <= wr_en && (s1_pos_reg.col == pos.col);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg     <= '0;
            upleft_reg   <= '0;
            max_reg      <= '0;
            top_row_reg  <= '0;
            left_col_reg <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                left_reg     <= '0;
                upleft_reg   <= '0;
                max_reg      <= '0;
                top_row_reg  <= '0;
                left_col_reg <= '0;
                ovf_reg      <= 1'b0;
            end
            else
            begin
                if (!s1_pos_reg.ignore)
                begin
                    left_reg   <= size_cur;
                    upleft_reg <= up;
                end
                if (better)
                begin
                    max_reg      <= size_cur;
                    top_row_reg  <= top_row_cur;
                    left_col_reg <= left_col_cur;
                end
                ovf_reg <= ovf_reg || s1_pos_reg.ignore;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            out_size_reg <= better ? size_cur : max_reg;
            out_row_reg  <= better ? top_row_cur : top_row_reg;
            out_col_reg  <= better ? left_col_cur : left_col_reg;
            out_ovf_reg  <= ovf_reg || s1_pos_reg.ignore;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.best_size    = out_size_reg;
    assign result.best_row     = out_row_reg;
    assign result.best_col     = out_col_reg;
    assign result.row_overflow = out_ovf_reg;

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_adv && s1_last_reg))
        else $error("result beat without a last cell");

    a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_last_reg) |=> (max_reg >= $past(max_reg)))
        else $error("best size shrank inside a map");

    a_empty_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_size_reg == '0) |-> (out_row_reg == '0 && out_col_reg == '0))
        else $error("empty result with nonzero corner");

    a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && out_valid_reg && !result.ready) |-> !accept)
        else $error("cell taken while stage is blocked");

endmodule
`default_nettype wire

// File: rtl/core/lesf_pos.sv
`default_nettype none
module lesf_pos (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [lesf_pkg::CFG_W-1:0] map_cols,
    input  wire logic                       advance,
    input  wire logic                       last,
    output lesf_pkg::pos_t                  pos
);

    lesf_pkg::col_t col_reg, col_next;
    lesf_pkg::row_t row_reg, row_next;
    logic [lesf_pkg::COL_W:0] cols;
    logic [lesf_pkg::COL_W:0] col_inc;
    logic                     wrap_in;
    lesf_pkg::col_t           col_cur;
    lesf_pkg::row_t           row_cur;

    always_comb
    begin
        if (map_cols == '0)
        begin
            cols = (lesf_pkg::COL_W+1)'(1);
        end
        else if (map_cols > lesf_pkg::CFG_W'(lesf_pkg::MAX_COLS))
        begin
            cols = (lesf_pkg::COL_W+1)'(lesf_pkg::MAX_COLS);
        end
        else
        begin
            cols = (lesf_pkg::COL_W+1)'(map_cols);
        end

        // A column left past a narrowed width starts the next row
        wrap_in = {1'b0, col_reg} >= cols;
        col_cur = wrap_in ? '0 : col_reg;
        row_cur = wrap_in ? lesf_pkg::row_inc(row_reg) : row_reg;

        col_inc = {1'b0, col_cur} + 1'b1;
        if (col_inc >= cols)
        begin
            col_next = '0;
            row_next = lesf_pkg::row_inc(row_cur);
        end
        else
        begin
            col_next = col_inc[lesf_pkg::COL_W-1:0];
            row_next = row_cur;
        end

        if (last)
        begin
            col_next = '0;
            row_next = '0;
        end

        pos.col    = col_cur;
        pos.row    = row_cur;
        pos.ignore = row_cur >= lesf_pkg::ROW_W'(lesf_pkg::MAX_ROWS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule
`default_nettype wire

// File: sim/lesf_square_checker.sv
module lesf_square_checker
    import lesf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    lesf_cell_if                  cells,
    lesf_result_if                result,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    output int                    mismatches,
    output int                    squares_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        size_t    size;
        out_pos_t row;
        out_pos_t col;
        logic     overflow;
    } square_t;

    logic [CFG_W-1:0] row_width;
    size_t            line_sizes [MAX_COLS];
    size_t            left_sz;
    size_t            diag_sz;
    size_t            best_sz;
    logic [10:0]      col_pos;
    row_t             row_pos;
    int               best_bottom;
    int               best_right;
    bit               overflowed;
    square_t          pending_squares [$];
    square_t          want_sq;
    square_t          got_sq;

    function automatic void clear_map();
        foreach (line_sizes[i])
            line_sizes[i] = '0;
        left_sz     = '0;
        diag_sz     = '0;
        best_sz     = '0;
        col_pos     = '0;
        row_pos     = '0;
        best_bottom = 0;
        best_right  = 0;
        overflowed  = 1'b0;
    endfunction

    // Wrap to the next row once the column reaches the row width; rows saturate.
    function automatic void wrap_row(input int cols);
        if (col_pos >= cols)
        begin
            col_pos = '0;
            if (row_pos < MAX_ROWS)
                row_pos = row_pos + 1'b1;
        end
    endfunction

    function automatic void scan_cell(input logic [CHAR_W-1:0] ch, input logic last_c);
        int      cols;
        size_t   up;
        size_t   lft;
        size_t   ul;
        size_t   m;
        size_t   s;
        square_t rpt;
        cols = (row_width == 0) ? 1 : (row_width > MAX_COLS) ? MAX_COLS : int'(row_width);
        wrap_row(cols);
        if (row_pos >= MAX_ROWS)
            overflowed = 1'b1;
        else
        begin
            up  = (row_pos == 0) ? size_t'(0) : line_sizes[col_pos[COL_W-1:0]];
            lft = (col_pos == 0) ? size_t'(0) : left_sz;
            ul  = (col_pos == 0 || row_pos == 0) ? size_t'(0) : diag_sz;
            if (ch == FREE_CELL)
            begin
                m = (up < lft) ? up : lft;
                if (ul < m)
                    m = ul;
                s = m + 1'b1;
            end
            else
                s = '0;
            line_sizes[col_pos[COL_W-1:0]] = s;
            left_sz = s;
            diag_sz = up;
            // Strictly larger only: the first square of a size in raster order wins.
            if (s > best_sz)
            begin
                best_sz     = s;
                best_bottom = int'(row_pos);
                best_right  = int'(col_pos);
            end
        end
        col_pos = col_pos + 1'b1;
        wrap_row(cols);
        if (last_c)
        begin
            rpt = '0;
            rpt.size = best_sz;
            if (best_sz != 0)
            begin
                rpt.row = out_pos_t'(best_bottom + 1 - int'(best_sz));
                rpt.col = out_pos_t'(best_right + 1 - int'(best_sz));
            end
            rpt.overflow = overflowed;
            pending_squares.push_back(rpt);
            clear_map();
        end
    endfunction

    task automatic note_mismatch(input string tag, input square_t want, input square_t got);
        if (mismatches < 10)
            $display("%0t %s: expected size=%0d row=%0d col=%0d ovf=%0d, %s",
                     $realtime, tag, want.size, want.row, want.col, want.overflow,
                     $sformatf("got size=%0d row=%0d col=%0d ovf=%0d",
                               got.size, got.row, got.col, got.overflow));
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width = MAP_COLS_RESET;
            clear_map();
            pending_squares.delete();
            mismatches  = 0;
            squares_due = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got_sq.size     = result.best_size;
                got_sq.row      = result.best_row;
                got_sq.col      = result.best_col;
                got_sq.overflow = result.row_overflow;
                if (pending_squares.size() == 0)
                    note_mismatch("result with no map pending", '0, got_sq);
                else
                begin
                    want_sq = pending_squares.pop_front();
                    if (got_sq !== want_sq)
                        note_mismatch("square mismatch", want_sq, got_sq);
                end
            end
            if (cells.valid && cells.ready)
                scan_cell(cells.cell_char, cells.last_cell);
            if (cfg_wr_en)
                row_width = cfg_wr_data;
            squares_due = pending_squares.size();
        end
    end

endmodule

// File: sim/tb_largest_empty_square_finder_top.sv
module tb_largest_empty_square_finder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lesf_pkg::*;

    localparam int                QUIET_LIMIT = 1000;
    localparam logic [CHAR_W-1:0] OBSTACLE    = "o";

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    bit               idle_on;
    int               mismatches;
    int               squares_due;

    lesf_cell_if   cell_bus ();
    lesf_result_if result_bus ();

    largest_empty_square_finder_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cells       (cell_bus),
        .result      (result_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    lesf_square_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cells       (cell_bus),
        .result      (result_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .squares_due (squares_due)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [CHAR_W-1:0] blocked_byte();
        logic [CHAR_W-1:0] b;
        b = CHAR_W'($urandom_range(0, 255));
        if (b == FREE_CELL)
            b = OBSTACLE;
        return b;
    endfunction

    // Entered and left at a falling edge; hold the beat until it is taken.
    task automatic push_cell(input logic [CHAR_W-1:0] ch, input logic last_c);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cell_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        cell_bus.valid     <= 1'b1;
        cell_bus.cell_char <= ch;
        cell_bus.last_cell <= last_c;
        do
            @(posedge clk);
        while (!(cell_bus.valid === 1'b1 && cell_bus.ready === 1'b1));
        @(negedge clk);
    endtask

    task automatic send_map(input int n, input int free_pct);
        for (int i = 0; i < n; i++)
            push_cell(($urandom_range(0, 99) < free_pct) ? FREE_CELL : blocked_byte(), i == n - 1);
    endtask

    // Stop sending until every square is back, then let the line buffer write settle.
    task automatic drain_squares();
        cell_bus.valid <= 1'b0;
        while (squares_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_row_width(input logic [CFG_W-1:0] w);
        drain_squares();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        int stall;
        stall = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                stall--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                result_bus.ready <= 1'b0;
                stall = $urandom_range(1, 6) - 1;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cell_bus.valid && cell_bus.ready) || (result_bus.valid && result_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int w;
        int eff;
        int n;
        int rand_items;
        int rand_maps;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        cell_bus.valid     = 1'b0;
        cell_bus.cell_char = '0;
        cell_bus.last_cell = 1'b0;
        idle_on            = 1'b1;
        rand_items         = 0;
        rand_maps          = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset width of 16: a 2x2 square only forms if row 1 starts at cell 16.
        for (int i = 0; i < 18; i++)
        begin
            if (i == 2)
                push_cell(OBSTACLE, 1'b0);
            else if (i < 5 || i >= 16)
                push_cell(FREE_CELL, i == 17);
            else
                push_cell(blocked_byte(), 1'b0);
        end

        // Width 0 acts as one column; byte extremes block.
        set_row_width(11'd0);
        push_cell(8'h00, 1'b0);
        push_cell(FREE_CELL, 1'b0);
        push_cell(FREE_CELL, 1'b0);
        push_cell(8'hFF, 1'b1);

        // Tie among three unit squares: the earliest one stays.
        set_row_width(11'd4);
        push_cell(FREE_CELL, 1'b0);
        push_cell(OBSTACLE, 1'b0);
        push_cell(FREE_CELL, 1'b0);
        push_cell(FREE_CELL, 1'b1);
        // Map of one blocked cell: no square at all.
        push_cell(OBSTACLE, 1'b1);

        // Width past the limit clamps to the widest row: a 2x2 square forms only if
        // row 1 starts right after the last column, which is free as well.
        set_row_width(11'd2047);
        for (int i = 0; i < MAX_COLS + 2; i++)
            push_cell((i < 2 || i >= MAX_COLS - 1) ? FREE_CELL : blocked_byte(),
                      i == MAX_COLS + 1);

        set_row_width(11'd1024);
        send_map(40, 85);

        // Single column past the row limit: rows from the limit on only flag overflow.
        set_row_width(11'd1);
        for (int i = 0; i < MAX_ROWS + 6; i++)
            push_cell((i >= MAX_ROWS - 1) ? FREE_CELL : blocked_byte(), i == MAX_ROWS + 5);

        while (rand_items < 500 || rand_maps < 30)
        begin
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            eff = (w == 0) ? 1 : w;
            set_row_width(CFG_W'(w));
            repeat ($urandom_range(1, 4))
            begin
                n = $urandom_range(1, 6) * eff - $urandom_range(0, eff - 1);
                send_map(n, ($urandom_range(0, 4) == 0) ? 30 : 88);
                rand_items += n;
                rand_maps++;
                if (rand_items >= 400)
                    idle_on = 1'b0;
            end
        end

        drain_squares();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && squares_due == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
